>>> hdl/tpe_pkg.sv
// Package with the shared types and constants of the trivariate polynomial evaluator.
package tpe_pkg;

   localparam int DATA_W = 32;
   localparam int EXP_W  = 5;

   // Request kinds.
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_EVAL   = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic signed [31:0] coef_in;
      logic [4:0]        exp_x_in;
      logic [4:0]        exp_y_in;
      logic [4:0]        exp_z_in;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } tpe_request_type;

   typedef struct packed {
      logic signed [31:0] poly_value;
      logic              term_dropped;
   } tpe_response_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL
   } tpe_state_type;

endpackage

>>> hdl/trivariate_polynomial_evaluator.sv
// Trivariate polynomial evaluator: term table and sequenced evaluation with one shared multiplier.
// An append is taken while idle and busy stays low. An evaluation fetches, loads and then
//   multiplies out each stored term in turn, the result strobe following the last one;
//   an empty table answers without leaving idle. The single 32x32 multiplier gives one product
//   per cycle; while an evaluation runs, busy is high and no new request is taken.
// Reset (synchronous, active high) empties the term table and clears the sticky drop flag;
// the receiver cannot stall, so each result is shown for exactly one cycle.
module trivariate_polynomial_evaluator #(
   parameter int MAX_TERMS = 64,
   parameter int MAX_EXP   = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  tpe_pkg::tpe_request_type  req_data,
   output logic                      rsp_strobe,
   output tpe_pkg::tpe_response_type rsp_data
);

   import tpe_pkg::*;

   localparam int AddrW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CountW = $clog2(MAX_TERMS + 1);
   localparam int WordW  = DATA_W + 3 * EXP_W;

   // Exponents above the maximum are saturated when a term is stored.
   function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
      logic [EXP_W-1:0] v;
      v = e;
      if (int'(e) > MAX_EXP) begin
         v = EXP_W'(MAX_EXP);
      end
      return v;
   endfunction

   tpe_state_type state_ff, state_in;

   logic [CountW-1:0] count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [AddrW-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [EXP_W-1:0]  ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_drop_ff, rsp_drop_in;

   logic              accept;
   logic              table_full;
   logic              last_term;
   logic              wr_en;
   logic [WordW-1:0]  wr_word;
   logic [WordW-1:0]  rd_word;
   logic [DATA_W-1:0] mul_base;
   logic [DATA_W-1:0] mul_res;
   logic              mul_done;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign table_full = (count_ff == CountW'(MAX_TERMS));
   assign last_term  = (CountW'(idx_ff) == (count_ff - CountW'(1)));

   // A term is written at the current fill position; the stored word packs the coefficient
   // above the three saturated exponents.
   assign wr_en   = accept && (req_data.req_type == REQ_APPEND) && !table_full;
   assign wr_word = {req_data.coef_in,
                     clamp_exp(req_data.exp_z_in),
                     clamp_exp(req_data.exp_y_in),
                     clamp_exp(req_data.exp_x_in)};

   tpe_ram #(
      .WIDTH(WordW),
      .DEPTH(MAX_TERMS)
   ) u_term_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AddrW-1:0]),
      .wr_data(wr_word),
      .rd_addr(idx_ff),
      .rd_data(rd_word)
   );

   // The shared multiplier works through the x, then y, then z powers of the current term,
   // one factor per cycle, counting each exponent down to zero.
   always_comb begin
      if (ex_ff != '0) begin
         mul_base = px_ff;
      end else if (ey_ff != '0) begin
         mul_base = py_ff;
      end else begin
         mul_base = pz_ff;
      end
   end

   assign mul_res  = acc_ff * mul_base;
   assign mul_done = (ex_ff == '0) && (ey_ff == '0) && (ez_ff == '0);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.req_type == REQ_EVAL) && (count_ff != '0)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) begin
               state_in = last_term ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      count_in      = count_ff;
      drop_in       = drop_ff;
      idx_in        = idx_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      ez_in         = ez_ff;
      acc_in        = acc_ff;
      sum_in        = sum_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_drop_in   = rsp_drop_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_APPEND) begin
                  if (table_full) begin
                     drop_in = 1'b1;
                  end else begin
                     count_in = count_ff + CountW'(1);
                  end
               end else begin
                  px_in  = req_data.point_x;
                  py_in  = req_data.point_y;
                  pz_in  = req_data.point_z;
                  idx_in = '0;
                  sum_in = '0;
                  // With no terms stored the sum is zero and is reported right away.
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_drop_in   = drop_ff;
                  end
               end
            end
         end
         ST_FETCH: begin
         end
         ST_LOAD: begin
            acc_in = rd_word[WordW-1 -: DATA_W];
            ex_in  = rd_word[EXP_W-1:0];
            ey_in  = rd_word[2*EXP_W-1 -: EXP_W];
            ez_in  = rd_word[3*EXP_W-1 -: EXP_W];
         end
         ST_MUL: begin
            if (mul_done) begin
               sum_in = sum_ff + acc_ff;
               idx_in = idx_ff + AddrW'(1);
               if (last_term) begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = sum_ff + acc_ff;
                  rsp_drop_in   = drop_ff;
               end
            end else begin
               acc_in = mul_res;
               if (ex_ff != '0) begin
                  ex_in = ex_ff - EXP_W'(1);
               end else if (ey_ff != '0) begin
                  ey_in = ey_ff - EXP_W'(1);
               end else begin
                  ez_in = ez_ff - EXP_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      ez_ff        <= ez_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      rsp_value_ff <= rsp_value_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_data.poly_value   = rsp_value_ff;
   assign rsp_data.term_dropped = rsp_drop_ff;

endmodule

>>> hdl/tpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
